### rtl/lpti_pkg.sv
// Shared types and constants for the line versus polygon intersection block.
package lpti_pkg;

  // Field widths fixed by the stream interface.
  localparam int unsigned FieldBits = 24;
  localparam int unsigned IdxBits   = 4;
  localparam int unsigned CntBits   = 5;
  localparam int unsigned DirBits   = 16;

  // Edge parameter: 16 fractional bits, one is exactly 1 << 16.
  localparam int unsigned FacBits = 16;
  localparam logic [FacBits:0] FacOne = {1'b1, {FacBits{1'b0}}};

  // Configuration register indexes.
  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] CFG_DIR_X        = 2'd1;
  localparam logic [1:0] CFG_DIR_Y        = 2'd2;

  // Request kinds carried in tuser.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // What the shared multiplier's product is for.
  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_DEN0,
    TAG_DEN1,
    TAG_NUM0,
    TAG_NUM1,
    TAG_NUM2,
    TAG_SX,
    TAG_SY
  } tag_e;

endpackage

### rtl/lpti_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lpti_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/line_polygon_two_intersections_core.sv
// Line versus polygon intersection core. Vertices are loaded one per request
// (tuser = 0) into two vertex RAMs; a query (tuser = 1) walks polygon edges
// 0..count-2 against the unbounded line through points A and B, keeps the
// first two crossings with edge parameter in [0,1], tests the closing edge
// only if exactly one crossing was found, and returns both points ordered
// along (dir_x, dir_y), or found = 0. Every request yields one result; a load
// result is all zero. A query holds the core through acceptance and the first
// vertex read, then, per tested edge, a RAM read, five products for the
// denominator and numerator, a range check, a restoring division for the edge
// parameter (skipped for a crossing at the far end of the edge) and two scaling
// products, and last the final ordering. A skipped edge ends after the check;
// the closing edge needs no RAM read. A count below two goes straight to the
// final ordering. The restoring divider for the edge parameter and the single
// shared multiplier set the query time. Vertex slots read by a query must have
// been loaded first; the RAMs have no reset.
module line_polygon_two_intersections_core #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned COORD_BITS   = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Slave request channel.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [3:0] vertex_index, [27:4] point_a_x, [51:28] point_a_y,
  // [75:52] point_b_x, [99:76] point_b_y, [103:100] zero
  input  logic [103:0]  s_axis_tdata,
  // [0] req_type
  input  logic [0:0]    s_axis_tuser,
  // Master result channel.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [23:0] first_x, [47:24] first_y, [71:48] second_x, [95:72] second_y
  output logic [95:0]   m_axis_tdata,
  // [0] found
  output logic [0:0]    m_axis_tuser,
  // Configuration write port.
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned D  = CB + 1;          // coordinate differences
  localparam int unsigned P  = 2 * D;           // multiplier product
  localparam int unsigned W  = 2 * CB + 4;      // numerator / divider sums
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned FB = lpti_pkg::FacBits;
  localparam int unsigned FW = lpti_pkg::FieldBits;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDW  = 4'd1;
  localparam logic [3:0] S_RDN  = 4'd2;
  localparam logic [3:0] S_CALC = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SCL  = 4'd6;
  localparam logic [3:0] S_NEXT = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  // Input field to internal coordinate: low CB bits, sign extended.
  function automatic logic signed [CB-1:0] to_c(input logic [FW-1:0] v);
    logic [CB+FW-1:0] w;
    w = {{CB{v[FW-1]}}, v};
    return w[CB-1:0];
  endfunction

  // Internal coordinate to output field: low bits, zero filled.
  function automatic logic [FW-1:0] to_o(input logic [CB-1:0] v);
    logic [CB+FW-1:0] w;
    w = {{FW{1'b0}}, v};
    return w[FW-1:0];
  endfunction

  function automatic logic signed [D-1:0] ext(input logic signed [CB-1:0] v);
    return {v[CB-1], v};
  endfunction

  function automatic logic signed [D-1:0] absd(input logic signed [D-1:0] v);
    return v[D-1] ? -v : v;
  endfunction

  // Request fields.
  logic               req_type;
  logic [3:0]         req_idx;
  logic signed [CB-1:0] in_ax, in_ay, in_bx, in_by;
  assign req_type = s_axis_tuser[0];
  assign req_idx  = s_axis_tdata[3:0];
  assign in_ax    = to_c(s_axis_tdata[27:4]);
  assign in_ay    = to_c(s_axis_tdata[51:28]);
  assign in_bx    = to_c(s_axis_tdata[75:52]);
  assign in_by    = to_c(s_axis_tdata[99:76]);

  // Configuration registers.
  logic [4:0]         vc_q;
  logic signed [15:0] dirx_q, diry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q   <= '0;
      dirx_q <= '0;
      diry_q <= 16'sd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lpti_pkg::CFG_VERTEX_COUNT: vc_q   <= cfg_data_i[4:0];
        lpti_pkg::CFG_DIR_X:        dirx_q <= cfg_data_i;
        lpti_pkg::CFG_DIR_Y:        diry_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Vertex RAMs.
  logic          s_acc;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CB-1:0] ram_rx, ram_ry;
  logic [AW+3:0] widx_ext;
  logic [CB-1:0] in_ax_u, in_ay_u;

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign widx_ext  = {{AW{1'b0}}, req_idx};
  assign ram_waddr = widx_ext[AW-1:0];
  assign ram_we    = s_acc && (req_type == lpti_pkg::REQ_LOAD) &&
                     (widx_ext < (AW+4)'(MAX_VERTICES));
  assign in_ax_u   = in_ax;
  assign in_ay_u   = in_ay;

  lpti_ram #(.WIDTH(CB), .DEPTH(MAX_VERTICES)) u_ram_x (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(in_ax_u),
    .raddr_i(ram_raddr), .rdata_o(ram_rx)
  );
  lpti_ram #(.WIDTH(CB), .DEPTH(MAX_VERTICES)) u_ram_y (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(in_ay_u),
    .raddr_i(ram_raddr), .rdata_o(ram_ry)
  );

  // Control state.
  logic [3:0]    state_q, state_d;
  logic [2:0]    step_q, step_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] n_q, n_d;
  logic [1:0]    hits_q, hits_d;
  logic          closing_q, closing_d;
  logic          ovalid_q, ovalid_d;
  lpti_pkg::tag_e mtag_q, mtag_d, ptag_q, ptag_d;

  // Datapath.
  logic signed [CB-1:0] qax_q, qay_q, qbx_q, qby_q, qax_d, qay_d, qbx_d, qby_d;
  logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q, ax_d, ay_d, bx_d, by_d;
  logic signed [CB-1:0] fx_q, fy_q, fx_d, fy_d;
  logic signed [CB-1:0] p0x_q, p0y_q, p1x_q, p1y_q, p0x_d, p0y_d, p1x_d, p1y_d;
  logic signed [CB-1:0] px_q, py_q, px_d, py_d;
  logic signed [D-1:0]  mula_q, mulb_q, mula_d, mulb_d;
  logic signed [P-1:0]  prod_q, prod_d;
  logic signed [W-1:0]  den_q, num_q, r_q, den_d, num_d, r_d;
  logic [FB:0]          fac_q, fac_d;
  logic                 ofound_q, ofound_d;
  logic [FW-1:0]        o0x_q, o0y_q, o1x_q, o1y_q, o0x_d, o0y_d, o1x_d, o1y_d;

  assign ram_raddr     = idx_q;
  assign s_axis_tready = (state_q == S_IDLE) && (!ovalid_q || m_axis_tready);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ofound_q;
  assign m_axis_tdata  = {o1y_q, o1x_q, o0y_q, o0x_q};

  always_comb begin
    logic signed [W-1:0]  pw, dm, nn, r2;
    logic signed [D-1:0]  dxv, dyv, mx, ddx, ddy;
    logic [D+FB:0]        fac_ext;
    logic [CW+4:0]        vc_ext;
    logic [CW-1:0]        ncl;
    logic [CW+AW:0]       nxt, nlim;
    logic [16:0]          mdx, mdy;
    logic                 swap;

    state_d = state_q;  step_d = step_q;  cnt_d = cnt_q;  idx_d = idx_q;
    n_d = n_q;  hits_d = hits_q;  closing_d = closing_q;  ovalid_d = ovalid_q;
    qax_d = qax_q;  qay_d = qay_q;  qbx_d = qbx_q;  qby_d = qby_q;
    ax_d = ax_q;  ay_d = ay_q;  bx_d = bx_q;  by_d = by_q;  fx_d = fx_q;  fy_d = fy_q;
    p0x_d = p0x_q;  p0y_d = p0y_q;  p1x_d = p1x_q;  p1y_d = p1y_q;
    px_d = px_q;  py_d = py_q;  den_d = den_q;  num_d = num_q;  r_d = r_q;
    fac_d = fac_q;  ofound_d = ofound_q;
    o0x_d = o0x_q;  o0y_d = o0y_q;  o1x_d = o1x_q;  o1y_d = o1y_q;
    mula_d = '0;  mulb_d = '0;  mtag_d = lpti_pkg::TAG_NONE;

    // Shared multiplier, one product per cycle.
    prod_d = mula_q * mulb_q;
    ptag_d = mtag_q;

    dxv     = ext(bx_q) - ext(ax_q);
    dyv     = ext(by_q) - ext(ay_q);
    fac_ext = {{D{1'b0}}, fac_q};
    pw      = {{(W-P){prod_q[P-1]}}, prod_q};
    mx      = prod_q[FB+D-1:FB];

    // Accumulate products as they come out of the multiplier.
    unique case (ptag_q)
      lpti_pkg::TAG_DEN0: den_d = pw;
      lpti_pkg::TAG_DEN1: den_d = den_q + pw;
      lpti_pkg::TAG_NUM0: num_d = pw;
      lpti_pkg::TAG_NUM1,
      lpti_pkg::TAG_NUM2: num_d = num_q + pw;
      lpti_pkg::TAG_SX: begin
        ddx  = ext(ax_q) + (dxv[D-1] ? -mx : mx);
        px_d = ddx[CB-1:0];
      end
      lpti_pkg::TAG_SY: begin
        ddy  = ext(ay_q) + (dyv[D-1] ? -mx : mx);
        py_d = ddy[CB-1:0];
      end
      default: ;
    endcase

    ddx = '0;  ddy = '0;
    dm = den_q[W-1] ? -den_q : den_q;
    nn = den_q[W-1] ? -num_q : num_q;
    r2 = {r_q[W-2:0], 1'b0};
    vc_ext = {{CW{1'b0}}, vc_q};
    ncl    = (vc_ext > (CW+5)'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_ext[CW-1:0];
    nxt    = {{(CW+1){1'b0}}, idx_q} + (CW+AW+1)'(1);
    nlim   = {{(AW+1){1'b0}}, n_q};
    mdx    = dirx_q[15] ? -{dirx_q[15], dirx_q} : {dirx_q[15], dirx_q};
    mdy    = diry_q[15] ? -{diry_q[15], diry_q} : {diry_q[15], diry_q};
    swap   = 1'b0;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          if (req_type == lpti_pkg::REQ_LOAD) begin
            ovalid_d = 1'b1;
            ofound_d = 1'b0;
            o0x_d = '0;  o0y_d = '0;  o1x_d = '0;  o1y_d = '0;
          end else begin
            qax_d = in_ax;  qay_d = in_ay;  qbx_d = in_bx;  qby_d = in_by;
            n_d = ncl;  hits_d = '0;  closing_d = 1'b0;  idx_d = '0;
            state_d = (ncl < CW'(2)) ? S_FIN : S_RDW;
          end
        end
      end
      S_RDW: state_d = S_RDN;
      S_RDN: begin
        if (idx_q == '0) begin
          ax_d = ram_rx;  ay_d = ram_ry;  fx_d = ram_rx;  fy_d = ram_ry;
          idx_d = AW'(1);
          state_d = S_RDW;
        end else begin
          bx_d = ram_rx;  by_d = ram_ry;
          step_d = '0;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        // a = edge start, b = edge end, A/B = query points.
        unique case (step_q)
          3'd0: begin
            mula_d = dyv;  mulb_d = ext(qbx_q) - ext(qax_q);  mtag_d = lpti_pkg::TAG_DEN0;
          end
          3'd1: begin
            mula_d = ext(qay_q) - ext(qby_q);  mulb_d = dxv;  mtag_d = lpti_pkg::TAG_DEN1;
          end
          3'd2: begin
            mula_d = ext(qbx_q);  mulb_d = ext(qay_q) - ext(ay_q);
            mtag_d = lpti_pkg::TAG_NUM0;
          end
          3'd3: begin
            mula_d = ext(qax_q);  mulb_d = ext(ay_q) - ext(qby_q);
            mtag_d = lpti_pkg::TAG_NUM1;
          end
          3'd4: begin
            mula_d = ext(ax_q);  mulb_d = ext(qby_q) - ext(qay_q);
            mtag_d = lpti_pkg::TAG_NUM2;
          end
          default: ;
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd6) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        den_d = dm;
        step_d = '0;
        cnt_d = '0;
        if (den_q == '0 || nn[W-1] || nn > dm) begin
          state_d = S_NEXT;
        end else if (nn == dm) begin
          fac_d = lpti_pkg::FacOne;
          state_d = S_SCL;
        end else begin
          r_d = nn;
          fac_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (r2 >= den_q) begin
          r_d = r2 - den_q;
          fac_d = {fac_q[FB-1:0], 1'b1};
        end else begin
          r_d = r2;
          fac_d = {fac_q[FB-1:0], 1'b0};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = S_SCL;
        end
      end
      S_SCL: begin
        unique case (step_q)
          3'd0: begin
            mula_d = absd(dxv);  mulb_d = fac_ext[D-1:0];  mtag_d = lpti_pkg::TAG_SX;
          end
          3'd1: begin
            mula_d = absd(dyv);  mulb_d = fac_ext[D-1:0];  mtag_d = lpti_pkg::TAG_SY;
          end
          default: ;
        endcase
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) begin
          if (hits_q == 2'd0) begin
            p0x_d = px_q;  p0y_d = py_q;  hits_d = 2'd1;
          end else begin
            p1x_d = px_q;  p1y_d = py_q;  hits_d = 2'd2;
          end
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (closing_q || hits_q == 2'd2) begin
          state_d = S_FIN;
        end else if (nxt < nlim) begin
          ax_d = bx_q;  ay_d = by_q;
          idx_d = idx_q + AW'(1);
          state_d = S_RDW;
        end else if (hits_q == 2'd1) begin
          // Closing edge from the last vertex back to vertex zero.
          ax_d = bx_q;  ay_d = by_q;  bx_d = fx_q;  by_d = fy_q;
          closing_d = 1'b1;
          step_d = '0;
          state_d = S_CALC;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ddx = ext(p1x_q) - ext(p0x_q);
        ddy = ext(p1y_q) - ext(p0y_q);
        if (mdx > mdy) begin
          swap = (ddx != '0) && (ddx[D-1] != dirx_q[15]);
        end else begin
          swap = (ddy != '0) && (ddy[D-1] != diry_q[15]);
        end
        ovalid_d = 1'b1;
        if (hits_q == 2'd2) begin
          ofound_d = 1'b1;
          o0x_d = to_o(swap ? p1x_q : p0x_q);
          o0y_d = to_o(swap ? p1y_q : p0y_q);
          o1x_d = to_o(swap ? p0x_q : p1x_q);
          o1y_d = to_o(swap ? p0y_q : p1y_q);
        end else begin
          ofound_d = 1'b0;
          o0x_d = '0;  o0y_d = '0;  o1x_d = '0;  o1y_d = '0;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      n_q       <= '0;
      hits_q    <= '0;
      closing_q <= 1'b0;
      ovalid_q  <= 1'b0;
      mtag_q    <= lpti_pkg::TAG_NONE;
      ptag_q    <= lpti_pkg::TAG_NONE;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      n_q       <= n_d;
      hits_q    <= hits_d;
      closing_q <= closing_d;
      ovalid_q  <= ovalid_d;
      mtag_q    <= mtag_d;
      ptag_q    <= ptag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qax_q <= qax_d;  qay_q <= qay_d;  qbx_q <= qbx_d;  qby_q <= qby_d;
    ax_q <= ax_d;  ay_q <= ay_d;  bx_q <= bx_d;  by_q <= by_d;
    fx_q <= fx_d;  fy_q <= fy_d;
    p0x_q <= p0x_d;  p0y_q <= p0y_d;  p1x_q <= p1x_d;  p1y_q <= p1y_d;
    px_q <= px_d;  py_q <= py_d;
    mula_q <= mula_d;  mulb_q <= mulb_d;  prod_q <= prod_d;
    den_q <= den_d;  num_q <= num_d;  r_q <= r_d;  fac_q <= fac_d;
    ofound_q <= ofound_d;
    o0x_q <= o0x_d;  o0y_q <= o0y_d;  o1x_q <= o1x_d;  o1y_q <= o1y_d;
  end

endmodule
